[rtl/sgbd_pkg.sv]
`default_nettype none

package sgbd_pkg;

  // Widths fixed by the coded format.
  localparam int M_W   = 16;  // Golomb divisor register
  localparam int REM_W = 16;  // remainder accumulator
  localparam int BL_W  = 4;   // remainder bits still to read (at most 15)
  localparam int B_W   = 5;   // ceil(log2 m), 0 to 16
  localparam int VAL_W = 17;  // signed output value

  localparam logic [M_W-1:0] GOLOMB_M_RESET = 16'd4;

  typedef enum logic [1:0] {
    PH_SIGN,
    PH_UNARY,
    PH_REM,
    PH_EXTRA
  } phase_t;

  // Number of bits needed for m - 1, which is ceil(log2 m) for m >= 1.
  function automatic logic [B_W-1:0] width_b(input logic [M_W-1:0] m_eff);
    logic [M_W-1:0] mm;
    logic [B_W-1:0] b;
    mm = m_eff - M_W'(1);
    b  = '0;
    for (int i = 0; i < M_W; i++) begin
      if (mm[i]) begin
        b = B_W'(i + 1);
      end
    end
    return b;
  endfunction

  // Truncation threshold t = 2^b - m, always below 2^15.
  function automatic logic [REM_W-1:0] thresh_t(input logic [M_W-1:0] m_eff,
                                                input logic [B_W-1:0] b);
    logic [M_W:0] full;
    full = ((M_W+1)'(1) << b) - {1'b0, m_eff};
    return full[REM_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/signed_golomb_bit_decoder.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata[0] = code_bit
// m_*       out        m_tvalid / m_tready  m_tdata[16:0] = decoded_value, m_tuser = overflow
// cfg_*     in         cfg_valid / cfg_ready  cfg_data = golomb_m
//
// One coded bit is taken per cycle unless a stalled m_tready holds the input register;
// a beat is decoded while it sits in the input register, and the result register
// takes the outcome of the beat that closes a codeword when the decode step moves.
// The result register frees its slot in the same cycle it is taken, so a stalled
// m_tready holds the input register and then s_tready.
// Reset (rst, synchronous) returns the decoder to the sign phase with m = 4.
module signed_golomb_bit_decoder
  import sgbd_pkg::*;
#(
  parameter int MAG_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Coded bit stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] code_bit, [7:1] zero
  // Decoded values.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [16:0] decoded_value, [23:17] zero
  output logic [0:0]       m_tuser,   // [0] overflow
  // Divisor register write.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data   // golomb_m
);

  localparam int PROD_W = MAG_BITS + M_W;
  localparam int MAG_W  = MAG_BITS + VAL_W;
  localparam logic [MAG_BITS-1:0] Q_MAX = '1;
  localparam logic [MAG_W-1:0] LIM_FULL = MAG_W'(Q_MAX);

  // Configuration register. Writes are always taken.
  logic [M_W-1:0] golomb_m;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      golomb_m <= GOLOMB_M_RESET;
    end else if (cfg_valid) begin
      golomb_m <= cfg_data;
    end
  end

  // Input register: holds one coded bit waiting to be decoded.
  logic s1_valid;
  logic s1_bit;
  logic s1_adv;

  // The decode step moves only when the result register can take a result.
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_bit <= s_tdata[0];
    end
  end

  // Codeword state.
  phase_t               phase, phase_next;
  logic                 sign_flag, sign_flag_next;
  logic [MAG_BITS-1:0]  quotient_count, quotient_count_next;
  logic [REM_W-1:0]     remainder_acc, remainder_acc_next;
  logic [BL_W-1:0]      bits_left, bits_left_next;
  logic                 sat_flag, sat_flag_next;

  // Divisor-derived values; a zero divisor behaves as one.
  logic [M_W-1:0]   m_eff;
  logic [B_W-1:0]   b_cur;
  logic [REM_W-1:0] t_cur;

  assign m_eff = (golomb_m == '0) ? M_W'(1) : golomb_m;
  assign b_cur = width_b(m_eff);
  assign t_cur = thresh_t(m_eff, b_cur);

  logic             emit;
  logic [REM_W:0]   rem;
  logic [REM_W:0]   acc_shift;
  logic [BL_W-1:0]  bl_dec;

  assign acc_shift = {remainder_acc, s1_bit};
  assign bl_dec    = (bits_left == '0) ? '0 : bits_left - BL_W'(1);

  always_comb begin
    phase_next          = phase;
    sign_flag_next      = sign_flag;
    quotient_count_next = quotient_count;
    remainder_acc_next  = remainder_acc;
    bits_left_next      = bits_left;
    sat_flag_next       = sat_flag;
    emit                = 1'b0;
    rem                 = '0;
    unique case (phase)
      PH_SIGN: begin
        sign_flag_next      = s1_bit;
        quotient_count_next = '0;
        remainder_acc_next  = '0;
        bits_left_next      = '0;
        sat_flag_next       = 1'b0;
        phase_next          = PH_UNARY;
      end
      PH_UNARY: begin
        if (s1_bit) begin
          if (quotient_count == Q_MAX) begin
            sat_flag_next = 1'b1;
          end else begin
            quotient_count_next = quotient_count + MAG_BITS'(1);
          end
        end else begin
          remainder_acc_next = '0;
          if (b_cur == '0) begin
            // Divisor of one: the zero closing the unary run ends the codeword.
            emit       = 1'b1;
            phase_next = PH_SIGN;
          end else begin
            bits_left_next = BL_W'(b_cur - B_W'(1));
            if (b_cur != B_W'(1)) begin
              phase_next = PH_REM;
            end else if (t_cur != '0) begin
              emit       = 1'b1;
              phase_next = PH_SIGN;
            end else begin
              phase_next = PH_EXTRA;
            end
          end
        end
      end
      PH_REM: begin
        remainder_acc_next = acc_shift[REM_W-1:0];
        bits_left_next     = bl_dec;
        if (bl_dec == '0) begin
          if (acc_shift[REM_W-1:0] < t_cur) begin
            emit       = 1'b1;
            rem        = {1'b0, acc_shift[REM_W-1:0]};
            phase_next = PH_SIGN;
          end else begin
            phase_next = PH_EXTRA;
          end
        end
      end
      PH_EXTRA: begin
        // Extended remainder; below the threshold it counts as zero.
        emit       = 1'b1;
        rem        = (acc_shift >= {1'b0, t_cur}) ? acc_shift - {1'b0, t_cur} : '0;
        phase_next = PH_SIGN;
      end
      default: begin
        phase_next = PH_SIGN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SIGN;
      sign_flag      <= 1'b0;
      quotient_count <= '0;
      remainder_acc  <= '0;
      bits_left      <= '0;
      sat_flag       <= 1'b0;
    end else if (s1_adv) begin
      phase          <= phase_next;
      sign_flag      <= sign_flag_next;
      quotient_count <= quotient_count_next;
      remainder_acc  <= remainder_acc_next;
      bits_left      <= bits_left_next;
      sat_flag       <= sat_flag_next;
    end
  end

  // Magnitude = quotient * m + remainder, clipped to the saturation limit.
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  mag_full;
  logic [MAG_W-1:0]  mag_clip;
  logic              mag_over;
  logic [VAL_W-1:0]  mag_low;
  logic [VAL_W-1:0]  value;

  assign prod     = PROD_W'(quotient_count) * PROD_W'(m_eff);
  assign mag_full = MAG_W'(prod) + MAG_W'(rem);
  assign mag_over = mag_full > LIM_FULL;
  assign mag_clip = mag_over ? LIM_FULL : mag_full;
  assign mag_low  = mag_clip[VAL_W-1:0];
  // A negative zero comes out as zero since 0 - 0 is 0.
  assign value    = sign_flag ? VAL_W'(0) - mag_low : mag_low;

  // Result register.
  logic [VAL_W-1:0] res_value;
  logic             res_over;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      res_value <= value;
      res_over  <= sat_flag | mag_over;
    end
  end

  assign m_tdata = {7'd0, res_value};
  assign m_tuser = res_over;

endmodule

`default_nettype wire
